@@ src/pedd_pkg.sv @@
// Shared types and constants of the palette error diffusion dither block.
package pedd_pkg;

   // Index table: one entry per 15-bit color (five bits per channel).
   localparam int TABLE_ENTRIES = 32768;
   localparam int TABLE_AW      = 15;

   // Widths of the configuration registers and of the register port.
   localparam int LINE_WIDTH_W  = 13;
   localparam int BAND_HEIGHT_W = 16;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   // Register values after reset.
   localparam logic                     DITHER_ENABLE_RST = 1'b0;
   localparam logic [LINE_WIDTH_W-1:0]  LINE_WIDTH_RST    = 13'd4096;
   localparam logic [BAND_HEIGHT_W-1:0] BAND_HEIGHT_RST   = 16'd65535;

   typedef enum logic [1:0] {
      ACTION_PIXEL         = 2'd0,
      ACTION_INDEX_WRITE   = 2'd1,
      ACTION_PALETTE_WRITE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_DITHER_ENABLE = 2'd0,
      CSR_LINE_WIDTH    = 2'd1,
      CSR_BAND_HEIGHT   = 2'd2
   } csr_index_type;

   // One diffused error term of one channel.
   typedef logic signed [7:0] err_type;

   // Errors that a pixel leaves for the row below: index 0 red, 1 green, 2 blue.
   typedef struct packed {
      err_type [2:0] diag;
      err_type [2:0] down;
   } pend_entry_type;

   typedef struct packed {
      logic [1:0]          action;
      logic [TABLE_AW-1:0] table_address;
      logic [23:0]         table_data;
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] color_index;
      logic       end_of_band;
   } rsp_payload_type;

endpackage

@@ src/pedd_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module pedd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/palette_error_diffusion_dither.sv @@
// Top level of the palette error diffusion dither block.
//
// This block turns a raster stream of 24-bit RGB pixels into 8-bit palette
// indices. Each request transfer is either a pixel, a write of one entry of
// the 32768-entry index table, or a write of one palette color; every pixel
// gives exactly one response transfer (its index and an end-of-band flag),
// and table writes give none. The top five bits of each channel of the
// (possibly dithered) pixel address the index table, and the index found
// there selects the palette color from which the error is taken. With
// dithering on, 3/8 of the error goes to the right neighbor, 3/8 to the
// pixel below and 1/4 to the pixel below and to the right; the errors for
// the next row live in a RAM with one entry per column. A pixel's error
// must come back from the index table read and then the palette read
// before the next pixel can be adjusted, so a pixel is taken only once
// the one before has its palette color; table writes may follow one
// another in every cycle in which no pixel is being adjusted. The
// response waits in a two-entry output queue, and a pixel is taken only
// while that queue has room for it. After reset the block clears the
// index table and the palette and takes no request in that time;
// configuration writes are taken at any time. Configuration must be
// changed only while no pixel is in flight.
module palette_error_diffusion_dither
   import pedd_pkg::*;
#(
   parameter int MAX_LINE_WIDTH  = 4096,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int COL_W   = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
   localparam int CNT_W   = $clog2(MAX_LINE_WIDTH + 1);
   localparam int CMP_W   = (CNT_W > LINE_WIDTH_W) ? CNT_W : LINE_WIDTH_W;
   localparam int PAL_AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int PEND_W  = $bits(pend_entry_type);

   // Adds a signed error to a channel value and clamps to 0..255.
   function automatic logic [7:0] clamp_add(input logic [7:0] base,
                                            input logic [7:0] delta);
      logic signed [9:0] sum;
      sum = $signed({2'b00, base}) + $signed({{2{delta[7]}}, delta});
      if (sum < 10'sd0) begin
         clamp_add = 8'd0;
      end else if (sum > 10'sd255) begin
         clamp_add = 8'd255;
      end else begin
         clamp_add = sum[7:0];
      end
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers. The port never waits.
   // ------------------------------------------------------------------
   logic                     dither_enable_ff;
   logic [LINE_WIDTH_W-1:0]  line_width_ff;
   logic [BAND_HEIGHT_W-1:0] band_height_ff;
   logic                     csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dither_enable_ff <= DITHER_ENABLE_RST;
         line_width_ff    <= LINE_WIDTH_RST;
         band_height_ff   <= BAND_HEIGHT_RST;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            CSR_DITHER_ENABLE: dither_enable_ff <= csr_pwdata[0];
            CSR_LINE_WIDTH:    line_width_ff    <= csr_pwdata[LINE_WIDTH_W-1:0];
            CSR_BAND_HEIGHT:   band_height_ff   <= csr_pwdata[BAND_HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_DITHER_ENABLE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, dither_enable_ff};
         CSR_LINE_WIDTH:    csr_prdata = {{(CSR_DATA_W-LINE_WIDTH_W){1'b0}}, line_width_ff};
         CSR_BAND_HEIGHT:   csr_prdata = {{(CSR_DATA_W-BAND_HEIGHT_W){1'b0}}, band_height_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Clearing pass over the index table and the palette after reset.
   // ------------------------------------------------------------------
   logic                clear_busy_ff;
   logic [TABLE_AW-1:0] clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_busy_ff) begin
         clear_addr_ff <= clear_addr_ff + TABLE_AW'(1);
         if (clear_addr_ff == TABLE_AW'(TABLE_ENTRIES - 1)) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Request acceptance. A pixel moves through three stages: B adjusts it
   // with the pending errors, C holds the index table read, D holds the
   // palette read and computes the new errors. Only one pixel is in flight
   // at a time. Table writes wait only in the clearing pass or while a pixel
   // is in B, so no palette write overtakes an earlier pixel's palette read.
   // ------------------------------------------------------------------
   logic       b_vld_ff, c_vld_ff, d_vld_ff;
   logic [1:0] fifo_count_ff;
   logic [2:0] fifo_after;
   logic       rsp_pop;
   logic       queue_room;
   logic       req_accept;
   logic       pixel_accept;
   logic       index_write_accept;
   logic       palette_write_accept;

   assign rsp_pop = rsp_valid && rsp_ready;

   always_comb begin
      // Results still owed to the queue once this edge has passed.
      fifo_after = {1'b0, fifo_count_ff} + {2'b00, d_vld_ff} - {2'b00, rsp_pop};
      queue_room = (fifo_after <= 3'd1);
      case (req_payload.action)
         ACTION_PIXEL:
            req_ready = !clear_busy_ff && !b_vld_ff && !c_vld_ff && queue_room;
         default:
            req_ready = !clear_busy_ff && !b_vld_ff;
      endcase
   end

   assign req_accept           = req_valid && req_ready;
   assign pixel_accept         = req_accept && (req_payload.action == ACTION_PIXEL);
   assign index_write_accept   = req_accept && (req_payload.action == ACTION_INDEX_WRITE);
   assign palette_write_accept = req_accept && (req_payload.action == ACTION_PALETTE_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= pixel_accept;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   // ------------------------------------------------------------------
   // Position in the band. Out-of-range widths are folded in here: a zero
   // width or height acts as one and a width above the line buffer acts
   // as the buffer size.
   // ------------------------------------------------------------------
   logic [COL_W-1:0]         column_count_ff;
   logic [BAND_HEIGHT_W-1:0] row_count_ff;
   logic [CMP_W-1:0]         cols_eff;
   logic [CMP_W-1:0]         col_next;
   logic [BAND_HEIGHT_W-1:0] rows_eff;
   logic [BAND_HEIGHT_W:0]   row_next;
   logic                     last_col;
   logic                     last_row;

   always_comb begin
      if (line_width_ff == '0) begin
         cols_eff = CMP_W'(1);
      end else if (CMP_W'(line_width_ff) > CMP_W'(MAX_LINE_WIDTH)) begin
         cols_eff = CMP_W'(MAX_LINE_WIDTH);
      end else begin
         cols_eff = CMP_W'(line_width_ff);
      end
      rows_eff = (band_height_ff == '0) ? BAND_HEIGHT_W'(1) : band_height_ff;
      col_next = CMP_W'(column_count_ff) + CMP_W'(1);
      row_next = {1'b0, row_count_ff} + (BAND_HEIGHT_W+1)'(1);
      last_col = (col_next >= cols_eff);
      last_row = (row_next >= {1'b0, rows_eff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else if (pixel_accept) begin
         if (last_col) begin
            column_count_ff <= '0;
            row_count_ff    <= last_row ? '0 : row_next[BAND_HEIGHT_W-1:0];
         end else begin
            column_count_ff <= col_next[COL_W-1:0];
         end
      end
   end

   // Context of the pixel in flight, held until the next pixel is taken.
   logic [2:0][7:0]  pix_rgb_ff;
   logic [COL_W-1:0] pix_col_ff;
   logic             pix_row_nz_ff;
   logic             pix_col_nz_ff;
   logic             pix_last_col_ff;
   logic             pix_last_row_ff;

   always_ff @(posedge clock) begin
      if (pixel_accept) begin
         pix_rgb_ff[0]   <= req_payload.red;
         pix_rgb_ff[1]   <= req_payload.green;
         pix_rgb_ff[2]   <= req_payload.blue;
         pix_col_ff      <= column_count_ff;
         pix_row_nz_ff   <= (row_count_ff != '0);
         pix_col_nz_ff   <= (column_count_ff != '0);
         pix_last_col_ff <= last_col;
         pix_last_row_ff <= last_row;
      end
   end

   // ------------------------------------------------------------------
   // Pending row errors. The entry of a pixel's column is read in the cycle
   // a pixel is taken. With a one-pixel line that read meets the write of
   // the same entry by the pixel before, so the written data is forwarded.
   // ------------------------------------------------------------------
   logic [PEND_W-1:0] pend_rdata;
   pend_entry_type    pend_wdata;
   pend_entry_type    pend_sel;
   logic              fwd_ff;
   pend_entry_type    fwd_data_ff;

   pedd_ram #(
      .WIDTH (PEND_W),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (d_vld_ff),
      .wr_addr (pix_col_ff),
      .wr_data (pend_wdata),
      .rd_addr (column_count_ff),
      .rd_data (pend_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= d_vld_ff && (pix_col_ff == column_count_ff);
      end
      fwd_data_ff <= pend_wdata;
   end

   assign pend_sel = fwd_ff ? fwd_data_ff : pend_entry_type'(pend_rdata);

   // ------------------------------------------------------------------
   // Stage B: apply diagonal, down and right errors in that order.
   // ------------------------------------------------------------------
   err_type [2:0]   held_diag_ff;
   err_type [2:0]   right_error_ff;
   logic [2:0][7:0] v_in;
   logic [2:0][7:0] v_ff;
   logic [TABLE_AW-1:0] index_rd_addr;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         v_in[k] = pix_rgb_ff[k];
         if (dither_enable_ff) begin
            if (pix_row_nz_ff) begin
               if (pix_col_nz_ff) begin
                  v_in[k] = clamp_add(v_in[k], held_diag_ff[k]);
               end
               v_in[k] = clamp_add(v_in[k], pend_sel.down[k]);
            end
            if (pix_col_nz_ff) begin
               v_in[k] = clamp_add(v_in[k], right_error_ff[k]);
            end
         end
      end
      index_rd_addr = {v_in[0][7:3], v_in[1][7:3], v_in[2][7:3]};
   end

   always_ff @(posedge clock) begin
      if (b_vld_ff) begin
         v_ff <= v_in;
         if (pix_row_nz_ff) begin
            held_diag_ff <= pend_sel.diag;
         end
      end
   end

   // ------------------------------------------------------------------
   // Index table and palette. Both are written by request transfers or by
   // the clearing pass; palette writes beyond the palette are dropped.
   // ------------------------------------------------------------------
   logic                index_wr_en;
   logic [TABLE_AW-1:0] index_wr_addr;
   logic [7:0]          index_wr_data;
   logic [7:0]          index_rdata;
   logic                palette_wr_en;
   logic [PAL_AW-1:0]   palette_wr_addr;
   logic [23:0]         palette_wr_data;
   logic [23:0]         palette_rdata;

   always_comb begin
      index_wr_en     = clear_busy_ff || index_write_accept;
      index_wr_addr   = clear_busy_ff ? clear_addr_ff : req_payload.table_address;
      index_wr_data   = clear_busy_ff ? 8'd0 : req_payload.table_data[7:0];
      palette_wr_en   = (clear_busy_ff && (clear_addr_ff < TABLE_AW'(PALETTE_ENTRIES)))
                     || (palette_write_accept
                         && ({1'b0, req_payload.table_address[7:0]} < 9'(PALETTE_ENTRIES)));
      palette_wr_addr = clear_busy_ff ? clear_addr_ff[PAL_AW-1:0]
                                      : req_payload.table_address[PAL_AW-1:0];
      palette_wr_data = clear_busy_ff ? 24'd0 : req_payload.table_data;
   end

   pedd_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_ENTRIES)
   ) u_index_ram (
      .clock   (clock),
      .wr_en   (index_wr_en),
      .wr_addr (index_wr_addr),
      .wr_data (index_wr_data),
      .rd_addr (index_rd_addr),
      .rd_data (index_rdata)
   );

   pedd_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (palette_wr_en),
      .wr_addr (palette_wr_addr),
      .wr_data (palette_wr_data),
      .rd_addr (index_rdata[PAL_AW-1:0]),
      .rd_data (palette_rdata)
   );

   // Stage C: keep the index; an index past the palette reads as black.
   logic [7:0] idx_ff;
   logic       idx_ok_ff;

   always_ff @(posedge clock) begin
      if (c_vld_ff) begin
         idx_ff    <= index_rdata;
         idx_ok_ff <= ({1'b0, index_rdata} < 9'(PALETTE_ENTRIES));
      end
   end

   // ------------------------------------------------------------------
   // Stage D: error against the palette color, split 3/8, 3/8 and 1/4,
   // each quotient truncated toward zero. In plain mode the error is zero,
   // so the line buffer still gets defined contents.
   // ------------------------------------------------------------------
   logic [23:0]              color;
   logic [2:0][7:0]          pc;
   logic signed [8:0]        err [3];
   logic signed [10:0]       err3 [3];
   logic signed [10:0]       err3_adj [3];
   logic signed [10:0]       q38 [3];
   logic signed [8:0]        err_adj [3];
   logic signed [8:0]        q4 [3];
   err_type [2:0]            right_error_in;

   always_comb begin
      color = idx_ok_ff ? palette_rdata : 24'd0;
      pc[0] = color[23:16];
      pc[1] = color[15:8];
      pc[2] = color[7:0];
      for (int k = 0; k < 3; k++) begin
         err[k] = dither_enable_ff ? ($signed({1'b0, v_ff[k]}) - $signed({1'b0, pc[k]}))
                                   : 9'sd0;
         err3[k]     = $signed({{2{err[k][8]}}, err[k]}) + $signed({err[k][8], err[k], 1'b0});
         err3_adj[k] = err3[k] + (err3[k][10] ? 11'sd7 : 11'sd0);
         q38[k]      = err3_adj[k] >>> 3;
         err_adj[k]  = err[k] + (err[k][8] ? 9'sd3 : 9'sd0);
         q4[k]       = err_adj[k] >>> 2;
         right_error_in[k]  = pix_last_col_ff ? 8'sd0 : q38[k][7:0];
         pend_wdata.down[k] = pix_last_row_ff ? 8'sd0 : q38[k][7:0];
         pend_wdata.diag[k] = (pix_last_row_ff || pix_last_col_ff) ? 8'sd0 : q4[k][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_error_ff <= '0;
      end else if (d_vld_ff) begin
         right_error_ff <= right_error_in;
      end
   end

   // ------------------------------------------------------------------
   // Two-entry response queue.
   // ------------------------------------------------------------------
   rsp_payload_type fifo_ff [2];
   rsp_payload_type rsp_push_data;
   logic            wr_ptr_ff;
   logic            rd_ptr_ff;

   assign rsp_push_data.color_index = idx_ff;
   assign rsp_push_data.end_of_band = pix_last_col_ff && pix_last_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         fifo_count_ff <= 2'd0;
      end else begin
         if (d_vld_ff) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (rsp_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fifo_count_ff <= fifo_count_ff + {1'b0, d_vld_ff} - {1'b0, rsp_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (d_vld_ff) begin
         fifo_ff[wr_ptr_ff] <= rsp_push_data;
      end
   end

   assign rsp_valid   = (fifo_count_ff != 2'd0);
   assign rsp_payload = fifo_ff[rd_ptr_ff];

endmodule

@@ tb/tb_palette_error_diffusion_dither.sv @@
// Self-checking testbench for the palette error diffusion dither block.
`timescale 1ns / 1ps

module tb_palette_error_diffusion_dither;
   import pedd_pkg::*;

   localparam int MAX_LINE_WIDTH   = 4096;
   localparam int PALETTE_ENTRIES  = 256;
   // About 700 random request transfers follow the directed table.
   localparam int RANDOM_ITEMS     = 700;
   // A pixel's response sits in a two-entry queue; this many quiet cycles
   // after the last response leave the block idle before a register is
   // written.
   localparam int SETTLE_CYCLES    = 12;
   // The response side stops once for this long while pixels keep coming.
   localparam int LONG_HOLD_CYCLES = 200;
   // Clearing the tables after reset comes first. The slowest correct run
   // then adds, per transfer, a sender gap, the block's stages and a
   // receiver stall, plus the long hold and the settling pauses.
   // The limit is several times that sum.
   localparam int CYCLE_LIMIT      = 400000;
   localparam int HOT_COLORS       = 8;

   // The fourth action code is not used by the block and must be dropped.
   localparam logic [1:0] ACTION_UNUSED = 2'd3;

   typedef enum logic {ROW_REQ, ROW_REG} row_kind_type;

   // One row of the directed table: either a request transfer or a
   // register write. Where the response is obvious it is typed in.
   typedef struct {
      row_kind_type    kind;
      req_payload_type item;
      csr_index_type   reg_index;
      int unsigned     reg_value;
      bit              known;
      rsp_payload_type known_rsp;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   palette_error_diffusion_dither #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Mirror of the block's state, kept by the predictor below. The tables
   // start out cleared, just as the block leaves them after its clearing
   // pass.
   bit                            dither_en       = DITHER_ENABLE_RST;
   bit [LINE_WIDTH_W-1:0]         line_width_reg  = LINE_WIDTH_RST;
   bit [BAND_HEIGHT_W-1:0]        band_height_reg = BAND_HEIGHT_RST;
   bit [7:0]                      index_tbl   [TABLE_ENTRIES];
   bit [23:0]                     palette_tbl [PALETTE_ENTRIES];
   int                            pend_down   [MAX_LINE_WIDTH][3];
   int                            pend_diag   [MAX_LINE_WIDTH][3];
   int                            held_diag   [3];
   int                            right_err   [3];
   int                            col_cnt;
   int                            row_cnt;
   // Columns 0 .. pend_high-1 of the row error memory have been written.
   // A row below the first must never read past that point.
   int                            pend_high;

   // Responses still owed by the block, oldest first.
   rsp_payload_type               awaited_indices [$];

   bit [23:0]                     hot_colors [HOT_COLORS];
   bit                            idle_on = 1'b1;
   bit                            hold_request;
   int                            responses_seen;
   int                            fail_count;
   int                            cycle_count;

   always #1 clock = ~clock;

   // Watchdog: a hung handshake must not keep the run going forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("palette_error_diffusion_dither: mismatch");
         $finish;
      end
   end

   function automatic int clamp_channel(int x);
      if (x < 0) return 0;
      if (x > 255) return 255;
      return x;
   endfunction

   // Works out the response to one pixel and advances the mirrored state:
   // pending additions (diagonal, down, right), table lookup, palette
   // color, then the error split 3/8 right, 3/8 down and 1/4 down-right.
   function automatic rsp_payload_type dither_pixel(req_payload_type item);
      int              cols;
      int              rows;
      int              c;
      int              idx;
      int              addr15;
      int              e;
      int              v  [3];
      int              pc [3];
      bit              last_col;
      bit              last_row;
      bit              eob;
      bit [23:0]       color;
      rsp_payload_type res;

      // Out-of-range register values fold into the usable range.
      cols = (line_width_reg == 0) ? 1 : int'(line_width_reg);
      if (cols > MAX_LINE_WIDTH) cols = MAX_LINE_WIDTH;
      rows = (band_height_reg == 0) ? 1 : int'(band_height_reg);
      c = (col_cnt >= MAX_LINE_WIDTH) ? MAX_LINE_WIDTH - 1 : col_cnt;
      // A count at or past the end, after a register shrank, ends the row.
      last_col = (c + 1 >= cols);
      last_row = (row_cnt + 1 >= rows);

      v[0] = item.red;
      v[1] = item.green;
      v[2] = item.blue;
      if (dither_en) begin
         for (int k = 0; k < 3; k++) begin
            if (row_cnt > 0) begin
               if (c > 0) v[k] = clamp_channel(v[k] + held_diag[k]);
               v[k] = clamp_channel(v[k] + pend_down[c][k]);
            end
            if (c > 0) v[k] = clamp_channel(v[k] + right_err[k]);
         end
      end
      if (row_cnt > 0) begin
         for (int k = 0; k < 3; k++) held_diag[k] = pend_diag[c][k];
      end

      addr15 = ((v[0] >> 3) << 10) | ((v[1] >> 3) << 5) | (v[2] >> 3);
      idx    = index_tbl[addr15];
      color  = (idx < PALETTE_ENTRIES) ? palette_tbl[idx] : 24'd0;
      pc[0]  = color[23:16];
      pc[1]  = color[15:8];
      pc[2]  = color[7:0];

      // In plain mode the error is zero, so the row memory is still
      // written and dithering can be switched on in the middle of a band.
      for (int k = 0; k < 3; k++) begin
         e = dither_en ? v[k] - pc[k] : 0;
         right_err[k]    = last_col ? 0 : (3 * e) / 8;
         pend_down[c][k] = last_row ? 0 : (3 * e) / 8;
         pend_diag[c][k] = (last_row || last_col) ? 0 : e / 4;
      end
      if (c + 1 > pend_high) pend_high = c + 1;

      eob = 1'b0;
      if (last_col) begin
         col_cnt = 0;
         for (int k = 0; k < 3; k++) right_err[k] = 0;
         if (last_row) begin
            row_cnt = 0;
            eob     = 1'b1;
         end else begin
            row_cnt++;
         end
      end else begin
         col_cnt = c + 1;
      end

      res.color_index = idx[7:0];
      res.end_of_band = eob;
      return res;
   endfunction

   // Offers one request transfer after a random gap and waits until it is
   // taken. At that edge the mirror absorbs it and, for a pixel, the
   // expected response is queued (the typed one where the table gives it).
   task automatic send_req(req_payload_type item, bit known, rsp_payload_type known_rsp);
      int              gap;
      rsp_payload_type res;

      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);

      case (item.action)
         ACTION_PIXEL: begin
            res = dither_pixel(item);
            awaited_indices.push_back(known ? known_rsp : res);
         end
         ACTION_INDEX_WRITE:
            index_tbl[item.table_address] = item.table_data[7:0];
         ACTION_PALETTE_WRITE:
            if (item.table_address[7:0] < PALETTE_ENTRIES)
               palette_tbl[item.table_address[7:0]] = item.table_data;
         default: ;
      endcase
   endtask

   // Lets every owed response arrive, then waits out the settling pause so
   // that a table write still in the pipeline has finished.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (awaited_indices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write (setup then access) followed by a read back of the same
   // register. Bits above the register's width carry junk on the write.
   task automatic write_reg(csr_index_type which, int unsigned value);
      int unsigned mask;
      int unsigned wdata;

      case (which)
         CSR_DITHER_ENABLE: mask = 32'h1;
         CSR_LINE_WIDTH:    mask = 32'h1FFF;
         default:           mask = 32'hFFFF;
      endcase
      wdata = (value & mask) | ($urandom & ~mask);

      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);

      case (which)
         CSR_DITHER_ENABLE: dither_en       = wdata[0];
         CSR_LINE_WIDTH:    line_width_reg  = wdata[LINE_WIDTH_W-1:0];
         default:           band_height_reg = wdata[BAND_HEIGHT_W-1:0];
      endcase

      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (wdata & mask)) begin
         $display("%0t: register %s read back: expected %0h actual %0h",
                  $time, which.name(), wdata & mask, csr_prdata);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // The port goes idle before the next access starts.
      @(posedge clock);
   endtask

   function automatic stim_row_type pixel_row(bit [7:0] r, bit [7:0] g, bit [7:0] b);
      stim_row_type row;
      row.kind                    = ROW_REQ;
      row.item                    = '0;
      row.item.action             = ACTION_PIXEL;
      row.item.red                = r;
      row.item.green              = g;
      row.item.blue               = b;
      row.reg_index               = CSR_DITHER_ENABLE;
      row.reg_value               = 0;
      row.known                   = 1'b0;
      row.known_rsp               = '0;
      return row;
   endfunction

   function automatic stim_row_type pixel_known(bit [7:0] r, bit [7:0] g, bit [7:0] b,
                                                bit [7:0] idx, bit eob);
      stim_row_type row;
      row                         = pixel_row(r, g, b);
      row.known                   = 1'b1;
      row.known_rsp.color_index   = idx;
      row.known_rsp.end_of_band   = eob;
      return row;
   endfunction

   function automatic stim_row_type write_row(logic [1:0] act, bit [14:0] addr,
                                              bit [23:0] data);
      stim_row_type row;
      row                         = pixel_row(8'hFF, 8'hFF, 8'hFF);
      row.item.action             = act;
      row.item.table_address      = addr;
      row.item.table_data         = data;
      return row;
   endfunction

   function automatic stim_row_type reg_row(csr_index_type which, int unsigned value);
      stim_row_type row;
      row                         = pixel_row(8'h00, 8'h00, 8'h00);
      row.kind                    = ROW_REG;
      row.reg_index               = which;
      row.reg_value               = value;
      return row;
   endfunction

   // Random request with every field random. Most transfers are pixels;
   // half of those sit near a few hot colors whose index table entries get
   // written, so the lookups and the diffused errors vary.
   function automatic req_payload_type random_request();
      req_payload_type item;
      int              pick;
      int              h;

      item.table_address = TABLE_AW'($urandom_range(0, TABLE_ENTRIES - 1));
      item.table_data    = 24'($urandom_range(0, 24'hFFFFFF));
      item.red           = 8'($urandom_range(0, 255));
      item.green         = 8'($urandom_range(0, 255));
      item.blue          = 8'($urandom_range(0, 255));
      pick               = $urandom_range(0, 99);
      h                  = $urandom_range(0, HOT_COLORS - 1);
      if (pick < 70) begin
         item.action = ACTION_PIXEL;
         if ($urandom_range(0, 1)) begin
            item.red   = hot_colors[h][23:16] ^ 8'($urandom_range(0, 15));
            item.green = hot_colors[h][15:8]  ^ 8'($urandom_range(0, 15));
            item.blue  = hot_colors[h][7:0]   ^ 8'($urandom_range(0, 15));
         end
      end else if (pick < 90) begin
         item.action = ACTION_INDEX_WRITE;
         if ($urandom_range(0, 1))
            item.table_address = {hot_colors[h][23:19], hot_colors[h][15:11],
                                  hot_colors[h][7:3]};
         if ($urandom_range(0, 1)) item.table_data[7:0] = 8'($urandom_range(0, 15));
      end else if (pick < 98) begin
         item.action = ACTION_PALETTE_WRITE;
         if ($urandom_range(0, 1)) item.table_address[7:0] = 8'($urandom_range(0, 15));
      end else begin
         item.action = ACTION_UNUSED;
      end
      return item;
   endfunction

   // Response side: a random stall before each transfer, one long hold on
   // request while pixels keep coming, and a check of every transfer
   // against the oldest expected response.
   initial begin : response_side
      int              stall;
      rsp_payload_type want;

      rsp_ready = 1'b0;
      forever begin
         if (hold_request) begin
            stall        = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         // Before reset takes hold rsp_valid is unknown; that is no transfer.
         do @(posedge clock); while (rsp_valid !== 1'b1);

         responses_seen++;
         if (awaited_indices.size() == 0) begin
            $display("%0t: response with nothing expected: index %0d end_of_band %0b",
                     $time, rsp_payload.color_index, rsp_payload.end_of_band);
            fail_count++;
         end else begin
            want = awaited_indices.pop_front();
            if (rsp_payload.color_index !== want.color_index) begin
               $display("%0t: color_index: expected %0d actual %0d",
                        $time, want.color_index, rsp_payload.color_index);
               fail_count++;
            end
            if (rsp_payload.end_of_band !== want.end_of_band) begin
               $display("%0t: end_of_band: expected %0b actual %0b",
                        $time, want.end_of_band, rsp_payload.end_of_band);
               fail_count++;
            end
         end
      end
   end

   initial begin : request_side
      stim_row_type directed_rows [$];
      int           random_items;
      int           phase_no;
      int           burst;
      int unsigned  lw;
      int unsigned  bh;
      int           eff_width;
      req_payload_type item;

      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      // Directed part. Right after reset every table entry is zero, so the
      // first lookups give index 0. The unused action code is dropped.
      // Table writes keep only the low byte of an index and only the low
      // byte of a palette address. With both sizes at zero each pixel is
      // a whole band, and shrinking the width mid-row ends the row at once.
      directed_rows.push_back(pixel_known(8'h00, 8'h00, 8'h00, 8'd0, 1'b0));
      directed_rows.push_back(pixel_known(8'hFF, 8'hFF, 8'hFF, 8'd0, 1'b0));
      directed_rows.push_back(write_row(ACTION_UNUSED, 15'h7FFF, 24'hFFFFFF));
      directed_rows.push_back(write_row(ACTION_INDEX_WRITE, 15'h7FFF, 24'hFFFFFF));
      directed_rows.push_back(pixel_known(8'hFF, 8'hFF, 8'hFF, 8'd255, 1'b0));
      directed_rows.push_back(write_row(ACTION_PALETTE_WRITE, 15'h7FFF, 24'hFFFFFF));
      directed_rows.push_back(write_row(ACTION_PALETTE_WRITE, 15'h0100, 24'h102030));
      directed_rows.push_back(write_row(ACTION_INDEX_WRITE, 15'h0000, 24'hABCD05));
      directed_rows.push_back(pixel_known(8'h07, 8'h07, 8'h07, 8'd5, 1'b0));
      directed_rows.push_back(pixel_known(8'h08, 8'h00, 8'h00, 8'd0, 1'b0));
      directed_rows.push_back(reg_row(CSR_DITHER_ENABLE, 1));
      directed_rows.push_back(reg_row(CSR_LINE_WIDTH, 0));
      directed_rows.push_back(reg_row(CSR_BAND_HEIGHT, 0));
      directed_rows.push_back(pixel_known(8'hFF, 8'hFF, 8'hFF, 8'd255, 1'b1));
      directed_rows.push_back(pixel_known(8'h00, 8'h00, 8'h00, 8'd5, 1'b1));
      // A 2 x 2 band with dithering: every diffusion direction is used.
      directed_rows.push_back(reg_row(CSR_LINE_WIDTH, 2));
      directed_rows.push_back(reg_row(CSR_BAND_HEIGHT, 2));
      directed_rows.push_back(pixel_row(8'd200, 8'd100, 8'd50));
      directed_rows.push_back(pixel_row(8'd30, 8'd220, 8'd140));
      directed_rows.push_back(pixel_row(8'd250, 8'd5, 8'd128));
      directed_rows.push_back(pixel_row(8'd0, 8'd255, 8'd60));
      // A width above the maximum acts as the maximum; the largest height.
      directed_rows.push_back(reg_row(CSR_LINE_WIDTH, 8191));
      directed_rows.push_back(reg_row(CSR_BAND_HEIGHT, 65535));
      directed_rows.push_back(pixel_row(8'd17, 8'd34, 8'd51));
      directed_rows.push_back(reg_row(CSR_DITHER_ENABLE, 0));
      directed_rows.push_back(pixel_row(8'd90, 8'd90, 8'd90));
      directed_rows.push_back(reg_row(CSR_LINE_WIDTH, 3));
      directed_rows.push_back(pixel_row(8'd255, 8'd0, 8'd255));
      directed_rows.push_back(pixel_row(8'd128, 8'd128, 8'd128));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The block is still clearing its tables here; the first transfer
      // simply waits for ready.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG) begin
            settle_block();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_req(directed_rows[i].item, directed_rows[i].known,
                     directed_rows[i].known_rsp);
         end
      end

      // Random part, in phases. Between phases the block is drained and
      // all three registers get new values. The width is only widened past
      // the written part of the row memory at the top of a band.
      foreach (hot_colors[i]) hot_colors[i] = 24'($urandom_range(0, 24'hFFFFFF));
      random_items = 0;
      phase_no     = 0;
      while (random_items < RANDOM_ITEMS) begin
         settle_block();
         write_reg(CSR_DITHER_ENABLE, ($urandom_range(0, 3) != 0));

         case ($urandom_range(0, 9))
            0:       lw = 0;
            1:       lw = $urandom_range(MAX_LINE_WIDTH + 1, 8191);
            2:       lw = $urandom_range(13, 64);
            3:       lw = MAX_LINE_WIDTH;
            default: lw = $urandom_range(1, 12);
         endcase
         eff_width = (lw == 0) ? 1 : ((lw > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : lw);
         if (row_cnt != 0 && eff_width > pend_high) lw = pend_high;
         write_reg(CSR_LINE_WIDTH, lw);

         case ($urandom_range(0, 7))
            0:       bh = 0;
            1:       bh = $urandom_range(1000, 65535);
            default: bh = $urandom_range(1, 6);
         endcase
         write_reg(CSR_BAND_HEIGHT, bh);

         // Some phases run with no idling on either side.
         idle_on = ($urandom_range(0, 4) != 0);
         // In the third phase the response side stops for a long stretch
         // while requests keep flowing, so the block fills up and stalls.
         if (phase_no == 2) hold_request = 1'b1;

         burst = $urandom_range(40, 90);
         repeat (burst) begin
            item = random_request();
            send_req(item, 1'b0, '0);
            if (item.action != ACTION_UNUSED) random_items++;
         end
         phase_no++;
      end

      settle_block();
      if (fail_count == 0) begin
         $display("palette_error_diffusion_dither: match");
      end else begin
         $display("palette_error_diffusion_dither: mismatch");
      end
      $finish;
   end

endmodule
